/* sv/nrud_pkg.sv */
`timescale 1ns / 1ps

package nrud_pkg;

  localparam int unsigned FIELD_BITS = 63;

  typedef struct packed {
    logic [FIELD_BITS-1:0] dividend;
    logic [FIELD_BITS-1:0] divisor;
  } in_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] quotient;
    logic [FIELD_BITS-1:0] remainder;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ALIGN,
    ST_ITER,
    ST_FIX,
    ST_SHIFT,
    ST_DONE
  } state_t;

endpackage

/* sv/nrud_lead_one.sv */
`timescale 1ns / 1ps

module nrud_lead_one #(
  parameter int unsigned WIDTH = 63
) (
  input  logic [WIDTH-1:0]         vec,
  output logic [$clog2(WIDTH)-1:0] pos
);

  localparam int unsigned PW = $clog2(WIDTH);

  // position of the highest set bit, zero when nothing is set
  always_comb begin
    pos = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (vec[i]) begin
        pos = PW'(i);
      end
    end
  end

endmodule

/* sv/nonrestoring_unsigned_divider.sv */
`timescale 1ns / 1ps
// an input goes through check, align, iterate, fix-up and shift, then done; the
// shift is the distance between the leading ones of dividend and divisor (at most
// DATA_BITS-2); special cases (dividend below divisor, zero divisor) go from check
// to done; inputs wait until the result is registered; a held result keeps it busy
// reset: rst_n synchronous active low clears the sequencer and the output valid

module nonrestoring_unsigned_divider #(
  parameter int unsigned DATA_BITS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  nrud_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output nrud_pkg::out_t out_data
);

  import nrud_pkg::*;

  // working word is DATA_BITS wide with the top bit as sign
  localparam int unsigned W  = DATA_BITS;
  localparam int unsigned OW = DATA_BITS - 1;
  localparam int unsigned CW = $clog2(OW);

  state_t state_r, state_nxt;

  // operands, low DATA_BITS-1 bits only
  logic [OW-1:0] a_r, a_nxt;
  logic [OW-1:0] b_r, b_nxt;

  // datapath registers
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  aligned_r, aligned_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [OW-1:0] quo_r, quo_nxt;
  logic          sub_r, sub_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] sh_r, sh_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // output register
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  // leading-one positions
  logic [CW-1:0] lead_a, lead_b;

  // shared adder
  logic [W-1:0] add_x;
  logic         add_sub;
  logic [W-1:0] sum;
  logic         sum_neg;

  logic in_xfer;
  logic out_free;
  logic [63:0] rem_wide;

  nrud_lead_one #(.WIDTH(OW)) u_lead_a (.vec(a_r), .pos(lead_a));
  nrud_lead_one #(.WIDTH(OW)) u_lead_b (.vec(b_r), .pos(lead_b));

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // one add/subtract: iteration steps on acc, correction on the partial remainder
  assign add_x   = (state_r == ST_FIX) ? rem_r : acc_r;
  assign add_sub = (state_r == ST_ITER) && sub_r;
  assign sum     = add_sub ? (add_x - aligned_r) : (add_x + aligned_r);
  assign sum_neg = sum[W-1];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // dividend below divisor or zero divisor finish at once
        if (a_r < b_r || b_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_ALIGN;
        end
      end
      ST_ALIGN: state_nxt = ST_ITER;
      ST_ITER: begin
        if (cnt_r == sh_r) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX:   state_nxt = ST_SHIFT;
      ST_SHIFT: state_nxt = ST_DONE;
      ST_DONE: begin
        // wait until the output register is free
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign rem_wide = 64'(rem_r);

  // datapath and outputs
  always_comb begin
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    aligned_nxt   = aligned_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    sub_nxt       = sub_r;
    neg_nxt       = neg_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = (state_r != ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          a_nxt = in_data.dividend[OW-1:0];
          b_nxt = in_data.divisor[OW-1:0];
        end
      end
      ST_CHECK: begin
        quo_nxt = '0;
        if (a_r < b_r) begin
          rem_nxt = W'(a_r);
        end else if (b_r == '0) begin
          rem_nxt = '0;
        end else begin
          sh_nxt = lead_a - lead_b;
        end
      end
      ST_ALIGN: begin
        // divisor lined up under the dividend's leading one
        aligned_nxt = W'(b_r) << sh_r;
        acc_nxt     = W'(a_r);
        sub_nxt     = 1'b1;
        neg_nxt     = 1'b0;
        cnt_nxt     = '0;
      end
      ST_ITER: begin
        // the sign of the new partial remainder picks quotient bit and next op
        quo_nxt = {quo_r[OW-2:0], !sum_neg};
        neg_nxt = sum_neg;
        sub_nxt = !sum_neg;
        rem_nxt = sum;
        acc_nxt = {sum[W-2:0], 1'b0};
        cnt_nxt = cnt_r + CW'(1);
      end
      ST_FIX: begin
        // negative remainder gets the divisor added back
        if (neg_r) begin
          rem_nxt = sum;
        end
      end
      ST_SHIFT: begin
        rem_nxt = rem_r >> sh_r;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.quotient  = FIELD_BITS'(quo_r);
          out_data_nxt.remainder = rem_wide[FIELD_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    acc_r      <= acc_nxt;
    aligned_r  <= aligned_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    sub_r      <= sub_nxt;
    neg_r      <= neg_nxt;
    sh_r       <= sh_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/nrud_checker.sv */
`timescale 1ns / 1ps

module nrud_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input nrud_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input nrud_pkg::out_t out_data
);

  import nrud_pkg::*;

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // busy right after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a division is in flight");

  // a new result appears together with the return to idle
  a_rose_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result shown while still busy");

  // leaving busy only once the result sits in the output register
  a_fell_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) |-> out_valid)
    else $error("back to idle without a result");

endmodule

bind nonrestoring_unsigned_divider nrud_checker u_nrud_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

/* tb/nonrestoring_unsigned_divider_tb.sv */
`timescale 1ns / 1ps

module nonrestoring_unsigned_divider_tb;
  import nrud_pkg::*;

  // working width of the divider, top bit is the sign of the partial remainder
  localparam int unsigned WORK_BITS = 64;
  localparam logic [63:0] WORK_MASK = {64{1'b1}} >> (64 - WORK_BITS);
  localparam logic [63:0] OPERAND_MASK = {64{1'b1}} >> (65 - WORK_BITS);

  localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;
  localparam int DIRECTED_ROWS = 22;
  localparam int HOLDOFF_CYCLES = 300;     // long receiver hold-off, well past one division
  localparam int DRAIN_CYCLES = 80;        // settling time at the end, longer than the longest division
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_PRINTED = 50;

  typedef struct {
    in_t  operands;
    out_t result;
  } division_record_t;

  typedef struct {
    in_t  operands;
    bit   typed;        // result column below is used as is
    out_t result;
  } directed_row_t;

  bit   clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  division_record_t awaited_divisions[$];
  directed_row_t    directed_rows [DIRECTED_ROWS];
  division_record_t oldest;
  in_t              next_item;

  int mismatch_count;
  int cycle_count;
  int sender_idle_pct;
  int receiver_idle_pct;
  int holdoffs_requested;
  int holdoffs_granted;
  int holdoff_left;
  int n;

  nonrestoring_unsigned_divider #(
    .DATA_BITS(WORK_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // free-running clock, 4 ns period
  initial begin
    forever #2 clk = ~clk;
  end

  // position of the leading one, -1 for zero
  function automatic int leading_one_index(input logic [63:0] value);
    int pos;
    pos = -1;
    for (int k = 0; k < 64; k++) begin
      if (value[k]) pos = k;
    end
    return pos;
  endfunction

  // non-restoring division: align divisor under the dividend's leading one,
  // then one add or subtract per quotient bit, steered by the sign of the
  // partial remainder, with a final add-back when it ends negative
  function automatic out_t divide_nonrestoring(input in_t operands);
    logic [63:0] dividend_w;
    logic [63:0] divisor_w;
    logic [63:0] aligned;
    logic [63:0] partial;
    logic [63:0] quo;
    logic [63:0] rem;
    int          shift;
    int          step;
    bit          subtract;
    bit          negative;
    out_t        result;
    dividend_w = {1'b0, operands.dividend} & OPERAND_MASK;
    divisor_w  = {1'b0, operands.divisor} & OPERAND_MASK;
    quo = '0;
    rem = '0;
    if (dividend_w < divisor_w) begin
      // dividend below divisor passes straight through as the remainder
      rem = dividend_w;
    end else if (dividend_w != 0 && divisor_w != 0) begin
      shift    = leading_one_index(dividend_w) - leading_one_index(divisor_w);
      aligned  = (divisor_w << shift) & WORK_MASK;
      partial  = dividend_w;
      subtract = 1'b1;
      negative = 1'b0;
      for (step = 0; step <= shift; step++) begin
        if (subtract) partial = (partial - aligned) & WORK_MASK;
        else partial = (partial + aligned) & WORK_MASK;
        negative = partial[WORK_BITS-1];
        quo = {quo[62:0], ~negative};
        subtract = ~negative;
        rem = partial;
        partial = (partial << 1) & WORK_MASK;
      end
      if (negative) rem = (rem + aligned) & WORK_MASK;
      rem = rem >> shift;
    end
    result.quotient  = quo[FIELD_BITS-1:0];
    result.remainder = rem[FIELD_BITS-1:0];
    return result;
  endfunction

  // operand with a random number of significant bits, so every shift occurs
  function automatic logic [FIELD_BITS-1:0] random_operand();
    logic [63:0] raw;
    int unsigned keep;
    raw  = {$urandom, $urandom};
    keep = $urandom_range(63, 0);
    return raw[FIELD_BITS-1:0] >> (63 - keep);
  endfunction

  // mostly general pairs, with a share of the special cases mixed in
  function automatic in_t random_division();
    in_t         item;
    int unsigned kind;
    logic [FIELD_BITS-1:0] swap;
    item.dividend = random_operand();
    item.divisor  = random_operand();
    kind = $urandom_range(99);
    if (kind < 6) begin
      item.divisor = '0;
    end else if (kind < 12) begin
      item.divisor = item.dividend;
    end else if (kind < 20) begin
      // force dividend below divisor
      if (item.dividend > item.divisor) begin
        swap          = item.dividend;
        item.dividend = item.divisor;
        item.divisor  = swap;
      end
    end else if (kind < 24) begin
      item.dividend = FIELD_MAX;
    end else if (kind < 28) begin
      item.divisor = ($urandom_range(1) == 1) ? FIELD_MAX : 63'd1;
    end
    return item;
  endfunction

  task automatic report_mismatch(input string detail);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("%0t mismatch: %s", $time, detail);
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic offer_division(input in_t operands, input out_t expected);
    division_record_t record;
    in_t noise;
    record.operands = operands;
    record.result   = expected;
    while ($urandom_range(99) < sender_idle_pct) begin
      noise.dividend = random_operand();
      noise.divisor  = random_operand();
      in_valid <= 1'b0;
      in_data  <= noise;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= operands;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_divisions.push_back(record);
    @(negedge clk);
  endtask

  // drop valid and wait for every pending result, ends at a falling edge
  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_divisions.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver side: random stall, or a long hold-off when one is requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoffs_granted != holdoffs_requested) begin
        holdoffs_granted++;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  // result checker: each result transfer against the oldest pending division
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_divisions.size() == 0) begin
        report_mismatch($sformatf("result q=%h r=%h with nothing pending",
                                  out_data.quotient, out_data.remainder));
      end else begin
        oldest = awaited_divisions.pop_front();
        if (out_data.quotient !== oldest.result.quotient)
          report_mismatch($sformatf("%h / %h quotient %h, want %h",
                                    oldest.operands.dividend, oldest.operands.divisor,
                                    out_data.quotient, oldest.result.quotient));
        if (out_data.remainder !== oldest.result.remainder)
          report_mismatch($sformatf("%h / %h remainder %h, want %h",
                                    oldest.operands.dividend, oldest.operands.divisor,
                                    out_data.remainder, oldest.result.remainder));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    sender_idle_pct   = 14;
    receiver_idle_pct = 65;

    // directed rows: dividend, divisor, typed, quotient, remainder
    directed_rows = '{
      // zero operands and zero divisor
      '{{63'd0, 63'd0}, 1'b1, {63'd0, 63'd0}},
      '{{FIELD_MAX, 63'd0}, 1'b1, {63'd0, 63'd0}},
      '{{63'd0, FIELD_MAX}, 1'b1, {63'd0, 63'd0}},
      '{{63'd0, 63'd1}, 1'b1, {63'd0, 63'd0}},
      // extremes
      '{{63'd1, 63'd1}, 1'b1, {63'd1, 63'd0}},
      '{{FIELD_MAX, 63'd1}, 1'b1, {FIELD_MAX, 63'd0}},
      '{{FIELD_MAX, FIELD_MAX}, 1'b1, {63'd1, 63'd0}},
      '{{63'd1, FIELD_MAX}, 1'b1, {63'd0, 63'd1}},
      '{{63'h7FFF_FFFF_FFFF_FFFE, FIELD_MAX}, 1'b1, {63'd0, 63'h7FFF_FFFF_FFFF_FFFE}},
      '{{63'h4000_0000_0000_0000, 63'd1}, 1'b1, {63'h4000_0000_0000_0000, 63'd0}},
      '{{63'h4000_0000_0000_0000, 63'h4000_0000_0000_0000}, 1'b1, {63'd1, 63'd0}},
      // dividend just below divisor
      '{{63'h4000_0000_0000_0000, 63'h4000_0000_0000_0001}, 1'b1,
        {63'd0, 63'h4000_0000_0000_0000}},
      '{{63'd12345, 63'd12346}, 1'b1, {63'd0, 63'd12345}},
      // ordinary divisions, first step negative, alternating bit patterns
      '{{63'd100, 63'd7}, 1'b0, '0},
      '{{63'd7, 63'd2}, 1'b0, '0},
      '{{63'd6, 63'd3}, 1'b0, '0},
      '{{63'd16, 63'd3}, 1'b0, '0},
      '{{FIELD_MAX, 63'd2}, 1'b0, '0},
      '{{63'h4000_0000_0000_0000, 63'd3}, 1'b0, '0},
      '{{FIELD_MAX, 63'h3FFF_FFFF_FFFF_FFFF}, 1'b0, '0},
      '{{63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA}, 1'b0, '0},
      '{{63'h4000_0000_0000_0001, 63'd3}, 1'b0, '0}
    };

    // reset, released on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table under the first idling mix
    foreach (directed_rows[k]) begin
      offer_division(directed_rows[k].operands,
                     directed_rows[k].typed ? directed_rows[k].result
                                            : divide_nonrestoring(directed_rows[k].operands));
    end

    // random, sender seldom idle, receiver mostly stalled
    for (n = 0; n < 500; n++) begin
      next_item = random_division();
      offer_division(next_item, divide_nonrestoring(next_item));
    end
    drain_results();

    // random, the other way round
    sender_idle_pct   = 65;
    receiver_idle_pct = 14;
    for (n = 0; n < 500; n++) begin
      next_item = random_division();
      offer_division(next_item, divide_nonrestoring(next_item));
    end
    drain_results();

    // no idling; a long receiver hold-off first so the divider backs up
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    holdoffs_requested++;
    for (n = 0; n < 550; n++) begin
      next_item = random_division();
      offer_division(next_item, divide_nonrestoring(next_item));
    end
    drain_results();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
